[design/ppri_pkg.sv]
// ----------------------------------------------------------------------------
// Planar pose rollout integrator package
// Fixed-point formats, angle constants, arctangent table and saturation helper.
// ----------------------------------------------------------------------------
package ppri_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_ITERS = 16;

   localparam int DATA_W      = 32;
   localparam int TS_W        = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam int ANG_BITS     = 30;
   localparam int ATAN_ENTRIES = 24;
   localparam int ROT_STEPS    = (CORDIC_ITERS < ATAN_ENTRIES) ? CORDIC_ITERS : ATAN_ENTRIES;
   localparam int ITER_W       = $clog2(ATAN_ENTRIES);

   localparam int REM_W        = DATA_W + ANG_BITS - FRAC_BITS;
   localparam int REDUCE_STEPS = REM_W - 33;
   localparam int ANG_W        = 36;
   localparam int TRIG_W       = 34;
   localparam int MUL_W        = 34;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int SUM_W        = 64;
   localparam int STEP_W       = 34;
   localparam int SAT_W        = 36;

   localparam logic [REM_W-1:0]         Q30_TWO_PI_U = REM_W'(64'd6746518852);
   localparam logic signed [ANG_W-1:0]  Q30_TWO_PI   = ANG_W'(64'sd6746518852);
   localparam logic signed [ANG_W-1:0]  Q30_PI       = ANG_W'(64'sd3373259426);
   localparam logic signed [ANG_W-1:0]  Q30_HALF_PI  = ANG_W'(64'sd1686629713);
   localparam logic signed [TRIG_W-1:0] Q30_GAIN     = TRIG_W'(64'sd652032874);

   localparam logic [TS_W-1:0] TIME_STEP_RESET = TS_W'(3277);

   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLONOMIC = CSR_INDEX_W'(1);

   localparam logic [30:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
      31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
      31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
      31'd262143,    31'd131071,    31'd65535,     31'd32767,
      31'd16383,     31'd8191,      31'd4095,      31'd2047,
      31'd1023,      31'd511,       31'd255,       31'd127
   };

   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ITER_W-1:0] idx);
      logic signed [ANG_W-1:0] r;
      r = '0;
      if (int'(idx) < ATAN_ENTRIES) begin
         r = $signed({{(ANG_W-31){1'b0}}, ATAN_TABLE[idx]});
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      logic signed [DATA_W-1:0] r;
      hi = SAT_W'(64'sd2147483647);
      lo = SAT_W'(-64'sd2147483648);
      if (v > hi) begin
         r = hi[DATA_W-1:0];
      end else if (v < lo) begin
         r = lo[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

[design/planar_pose_rollout_integrator_core.sv]
// ----------------------------------------------------------------------------
// Planar pose rollout integrator core
// Dead-reckoning pose step in Q16.16: CORDIC heading, rotated velocity, dt scaling.
// ----------------------------------------------------------------------------
// The core is not ready from the acceptance of a transaction until its result:
// the heading is reduced modulo 2*pi on one compare and subtract unit,
// 16 CORDIC iterations run on one shift-add unit, and a single
// 34x34 multiplier is sequenced over 7 products. A result sits in an output
// register, so the next transaction is accepted while it waits; the core only
// holds in its final step while the previous result is still untaken.
// Configuration writes are always accepted and take effect at once.
module planar_pose_rollout_integrator_core
   import ppri_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_start_req,
   input  logic signed [DATA_W-1:0] req_start_x,
   input  logic signed [DATA_W-1:0] req_start_y,
   input  logic signed [DATA_W-1:0] req_start_yaw,
   input  logic signed [DATA_W-1:0] req_vel_forward,
   input  logic signed [DATA_W-1:0] req_vel_lateral,
   input  logic signed [DATA_W-1:0] req_vel_angular,
   input  logic                     req_last_step,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_pos_x,
   output logic signed [DATA_W-1:0] rsp_pos_y,
   output logic signed [DATA_W-1:0] rsp_pos_yaw,
   output logic                     rsp_end_of_trajectory,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_REDUCE, S_WRAP, S_FOLD, S_ROTATE, S_SIGN, S_MUL, S_DONE
   } state_type;

   localparam int CNT_W = ITER_W;

   localparam logic [CNT_W-1:0] MUL_VX_COS = CNT_W'(0);
   localparam logic [CNT_W-1:0] MUL_VX_SIN = CNT_W'(1);
   localparam logic [CNT_W-1:0] MUL_VY_SIN = CNT_W'(2);
   localparam logic [CNT_W-1:0] MUL_VY_COS = CNT_W'(3);
   localparam logic [CNT_W-1:0] MUL_WZ_DT  = CNT_W'(4);
   localparam logic [CNT_W-1:0] MUL_SX_DT  = CNT_W'(5);
   localparam logic [CNT_W-1:0] MUL_SY_DT  = CNT_W'(6);

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [TS_W-1:0]            ts_ff, ts_in;
   logic                       hol_ff, hol_in;
   logic signed [DATA_W-1:0]   heading_ff, heading_in;
   logic signed [DATA_W-1:0]   acc_x_ff, acc_x_in;
   logic signed [DATA_W-1:0]   acc_y_ff, acc_y_in;
   logic signed [DATA_W-1:0]   vx_ff, vx_in;
   logic signed [DATA_W-1:0]   vy_ff, vy_in;
   logic signed [DATA_W-1:0]   wz_ff, wz_in;
   logic                       last_ff, last_in;
   logic                       neg_ff, neg_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic signed [ANG_W-1:0]    ang_ff, ang_in;
   logic                       flip_ff, flip_in;
   logic signed [TRIG_W-1:0]   x_ff, x_in;
   logic signed [TRIG_W-1:0]   y_ff, y_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SUM_W-1:0]    sx_ff, sx_in;
   logic signed [SUM_W-1:0]    sy_ff, sy_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [DATA_W-1:0]   rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [DATA_W-1:0]   rsp_pos_yaw_ff, rsp_pos_yaw_in;
   logic                       rsp_eot_ff, rsp_eot_in;

   logic signed [REM_W-1:0]    hd_ext;
   logic signed [REM_W-1:0]    hd_scaled;
   logic [REM_W-1:0]           two_pi_sh;
   logic signed [ANG_W-1:0]    r_s;
   logic signed [TRIG_W-1:0]   x_sh;
   logic signed [TRIG_W-1:0]   y_sh;
   logic signed [MUL_W-1:0]    mul_a;
   logic signed [MUL_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [PROD_W-1:0]   prod_sh;
   logic signed [STEP_W-1:0]   step_val;
   logic signed [SUM_W-1:0]    sx_sh;
   logic signed [SUM_W-1:0]    sy_sh;
   logic signed [DATA_W-1:0]   acc_y_new;
   logic signed [MUL_W-1:0]    ts_op;

   assign req_ready             = (state_ff == S_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pos_x             = rsp_pos_x_ff;
   assign rsp_pos_y             = rsp_pos_y_ff;
   assign rsp_pos_yaw           = rsp_pos_yaw_ff;
   assign rsp_end_of_trajectory = rsp_eot_ff;

   assign hd_ext    = REM_W'(heading_ff);
   assign hd_scaled = hd_ext <<< (ANG_BITS - FRAC_BITS);
   assign two_pi_sh = Q30_TWO_PI_U << count_ff;
   assign r_s       = $signed(rem_ff[ANG_W-1:0]);
   assign x_sh      = x_ff >>> count_ff;
   assign y_sh      = y_ff >>> count_ff;
   assign prod_sh   = prod_ff >>> 16;
   assign step_val  = prod_sh[STEP_W-1:0];
   assign sx_sh     = sx_ff >>> ANG_BITS;
   assign sy_sh     = sy_ff >>> ANG_BITS;
   assign ts_op     = $signed({{(MUL_W-TS_W){1'b0}}, ts_ff});
   assign acc_y_new = sat32(SAT_W'(acc_y_ff) + SAT_W'(step_val));

   always_comb begin
      mul_a = MUL_W'(vx_ff);
      mul_b = x_ff;
      case (count_ff)
         MUL_VX_COS: begin
            mul_a = MUL_W'(vx_ff);
            mul_b = x_ff;
         end
         MUL_VX_SIN: begin
            mul_a = MUL_W'(vx_ff);
            mul_b = y_ff;
         end
         MUL_VY_SIN: begin
            mul_a = MUL_W'(vy_ff);
            mul_b = y_ff;
         end
         MUL_VY_COS: begin
            mul_a = MUL_W'(vy_ff);
            mul_b = x_ff;
         end
         MUL_WZ_DT: begin
            mul_a = MUL_W'(wz_ff);
            mul_b = ts_op;
         end
         MUL_SX_DT: begin
            mul_a = sx_sh[MUL_W-1:0];
            mul_b = ts_op;
         end
         MUL_SY_DT: begin
            mul_a = sy_sh[MUL_W-1:0];
            mul_b = ts_op;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ts_in          = ts_ff;
      hol_in         = hol_ff;
      heading_in     = heading_ff;
      acc_x_in       = acc_x_ff;
      acc_y_in       = acc_y_ff;
      vx_in          = vx_ff;
      vy_in          = vy_ff;
      wz_in          = wz_ff;
      last_in        = last_ff;
      neg_in         = neg_ff;
      rem_in         = rem_ff;
      ang_in         = ang_ff;
      flip_in        = flip_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      prod_in        = prod_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      rsp_pos_yaw_in = rsp_pos_yaw_ff;
      rsp_eot_in     = rsp_eot_ff;

      if (csr_valid) begin
         if (csr_index == CSR_TIME_STEP) begin
            ts_in = csr_data[TS_W-1:0];
         end else if (csr_index == CSR_HOLONOMIC) begin
            hol_in = csr_data[0];
         end
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_start_req) begin
                  acc_x_in   = req_start_x;
                  acc_y_in   = req_start_y;
                  heading_in = req_start_yaw;
               end
               vx_in    = req_vel_forward;
               vy_in    = req_vel_lateral;
               wz_in    = req_vel_angular;
               last_in  = req_last_step;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            neg_in   = hd_scaled[REM_W-1];
            rem_in   = hd_scaled[REM_W-1] ? REM_W'(-hd_scaled) : REM_W'(hd_scaled);
            count_in = CNT_W'(REDUCE_STEPS - 1);
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (rem_ff >= two_pi_sh) begin
               rem_in = rem_ff - two_pi_sh;
            end
            count_in = count_ff - CNT_W'(1);
            if (count_ff == '0) begin
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            if (r_s > Q30_PI) begin
               ang_in = neg_ff ? (Q30_TWO_PI - r_s) : (r_s - Q30_TWO_PI);
            end else begin
               ang_in = neg_ff ? -r_s : r_s;
            end
            state_in = S_FOLD;
         end
         S_FOLD: begin
            flip_in = 1'b0;
            if (ang_ff > Q30_HALF_PI) begin
               ang_in  = ang_ff - Q30_PI;
               flip_in = 1'b1;
            end else if (ang_ff < -Q30_HALF_PI) begin
               ang_in  = ang_ff + Q30_PI;
               flip_in = 1'b1;
            end
            x_in     = Q30_GAIN;
            y_in     = '0;
            count_in = '0;
            state_in = S_ROTATE;
         end
         S_ROTATE: begin
            if (!ang_ff[ANG_W-1]) begin
               x_in   = x_ff - y_sh;
               y_in   = y_ff + x_sh;
               ang_in = ang_ff - atan_q30(count_ff);
            end else begin
               x_in   = x_ff + y_sh;
               y_in   = y_ff - x_sh;
               ang_in = ang_ff + atan_q30(count_ff);
            end
            count_in = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(ROT_STEPS - 1)) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            if (flip_ff) begin
               x_in = -x_ff;
               y_in = -y_ff;
            end
            count_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = mul_p;
            case (count_ff)
               MUL_VX_SIN: begin
                  sx_in = prod_ff[SUM_W-1:0];
               end
               MUL_VY_SIN: begin
                  sy_in = prod_ff[SUM_W-1:0];
               end
               MUL_VY_COS: begin
                  if (hol_ff) begin
                     sx_in = sx_ff - prod_ff[SUM_W-1:0];
                  end
               end
               MUL_WZ_DT: begin
                  if (hol_ff) begin
                     sy_in = sy_ff + prod_ff[SUM_W-1:0];
                  end
               end
               MUL_SX_DT: begin
                  heading_in = sat32(SAT_W'(heading_ff) + SAT_W'(step_val));
               end
               MUL_SY_DT: begin
                  acc_x_in = sat32(SAT_W'(acc_x_ff) + SAT_W'(step_val));
               end
               default: begin
               end
            endcase
            count_in = count_ff + CNT_W'(1);
            if (count_ff == MUL_SY_DT) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               acc_y_in       = acc_y_new;
               rsp_valid_in   = 1'b1;
               rsp_pos_x_in   = acc_x_ff;
               rsp_pos_y_in   = acc_y_new;
               rsp_pos_yaw_in = heading_ff;
               rsp_eot_in     = last_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ts_ff        <= TIME_STEP_RESET;
         hol_ff       <= 1'b0;
         heading_ff   <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ts_ff        <= ts_in;
         hol_ff       <= hol_in;
         heading_ff   <= heading_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vx_ff          <= vx_in;
      vy_ff          <= vy_in;
      wz_ff          <= wz_in;
      last_ff        <= last_in;
      neg_ff         <= neg_in;
      rem_ff         <= rem_in;
      ang_ff         <= ang_in;
      flip_ff        <= flip_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      prod_ff        <= prod_in;
      sx_ff          <= sx_in;
      sy_ff          <= sy_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_pos_yaw_ff <= rsp_pos_yaw_in;
      rsp_eot_ff     <= rsp_eot_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("core ready right after accepting a transaction");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the final step");

   a_hold_on_full_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == S_DONE)
      else $error("final step left while output register still occupied");

   a_folded_angle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROTATE && count_ff == '0 |->
         ang_ff <= Q30_HALF_PI && ang_ff >= -Q30_HALF_PI)
      else $error("CORDIC started on an unfolded angle");

   a_rotate_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROTATE |-> count_ff < CNT_W'(ROT_STEPS))
      else $error("CORDIC iteration count out of range");
`endif

endmodule
